/* hw/rtl/qxmm_pkg.sv */
// Types, constants and helper functions for the quad X-frame motor mixer.
// No dependencies; imported by qxmm_mix_core and quad_x_motor_mixer_top.
package qxmm_pkg;

   localparam int unsigned DRV_W   = 11;   // motor drive before scaling
   localparam int unsigned AXIS_W  = 13;   // signed controller drives
   localparam int unsigned SPAN_W  = 10;
   localparam int unsigned PWM_W   = 13;
   localparam int unsigned SUM_W   = 16;   // wide enough for base plus three drives
   localparam int unsigned IDX_W   = 3;

   localparam logic [1:0] CMD_STICK_MIX = 2'd0;
   localparam logic [1:0] CMD_ALT_MIX   = 2'd1;
   localparam logic [1:0] CMD_DIRECT    = 2'd2;

   localparam logic [IDX_W-1:0] REG_THROTTLE_MIN = 3'd0;
   localparam logic [IDX_W-1:0] REG_THROTTLE_MAX = 3'd1;
   localparam logic [IDX_W-1:0] REG_HOVER        = 3'd2;
   localparam logic [IDX_W-1:0] REG_TILT_CENTER  = 3'd3;
   localparam logic [IDX_W-1:0] REG_TILT_SPAN    = 3'd4;
   localparam logic [IDX_W-1:0] REG_YAW_CENTER   = 3'd5;
   localparam logic [IDX_W-1:0] REG_YAW_SPAN     = 3'd6;

   localparam logic signed [SUM_W-1:0] DIRECT_ALT_LO = 16'sd1020;
   localparam logic signed [SUM_W-1:0] DIRECT_ALT_HI = 16'sd1950;
   localparam logic signed [SUM_W-1:0] WIDE_YAW_LO   = 16'sd1020;
   localparam logic signed [SUM_W-1:0] WIDE_YAW_HI   = 16'sd1980;
   localparam logic signed [SUM_W-1:0] STICK_MARGIN  = 16'sd50;
   localparam logic signed [SUM_W-1:0] DRIVE_MAX     = 16'sd2047;

   typedef struct packed {
      logic [DRV_W-1:0]  throttle_min;
      logic [DRV_W-1:0]  throttle_max;
      logic [DRV_W-1:0]  hover_throttle;
      logic [DRV_W-1:0]  tilt_center;
      logic [SPAN_W-1:0] tilt_span;
      logic [DRV_W-1:0]  yaw_center;
      logic [SPAN_W-1:0] yaw_span;
   } cfg_type;

   typedef struct packed {
      logic [1:0]               cmd;
      logic [DRV_W-1:0]         stick_throttle;
      logic signed [AXIS_W-1:0] alt_drive;
      logic signed [AXIS_W-1:0] roll_drive;
      logic signed [AXIS_W-1:0] pitch_drive;
      logic signed [AXIS_W-1:0] yaw_drive;
      logic                     armed;
      logic                     wide_yaw;
   } item_type;

   typedef struct packed {
      logic [PWM_W-1:0] pwm_ch4;
      logic [PWM_W-1:0] pwm_ch3;
      logic [PWM_W-1:0] pwm_ch2;
      logic [PWM_W-1:0] pwm_ch1;
   } result_type;

   // saturate to 0..2047 then scale by 10/4 (= *5 >> 1), truncating
   function automatic logic [PWM_W-1:0] scale_drive(input logic signed [SUM_W-1:0] d);
      logic [DRV_W-1:0] sat;
      logic [PWM_W:0]   x5;
      begin
         if (d < 0) begin
            sat = '0;
         end else if (d > DRIVE_MAX) begin
            sat = DRIVE_MAX[DRV_W-1:0];
         end else begin
            sat = d[DRV_W-1:0];
         end
         x5 = {3'b000, sat} + {1'b0, sat, 2'b00};
         scale_drive = x5[PWM_W:1];
      end
   endfunction

endpackage

/* hw/rtl/quad_x_motor_mixer_top.sv */
// Quad X-frame motor mixer: one control sample in, four PWM compare values out.
// Each transaction is captured in an input register, mixed by qxmm_mix_core in a
// single pass and held in the result register; a new transaction can be taken
// every cycle. Throughput is one transaction per cycle, limited only by
// rsp_tready. The user must write registers via the csr_ port only while
// idle; the block itself does not enforce this. An index beyond the register
// list is ignored. Depends on qxmm_pkg and qxmm_mix_core.
module quad_x_motor_mixer_top
   import qxmm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [10:0] csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [10:0] stick_throttle, [23:11] alt_drive, [36:24] roll_drive,
   // [49:37] pitch_drive, [62:50] yaw_drive, [63] armed, [64] wide_yaw
   input  logic [71:0] req_tdata,
   // [1:0] cmd
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [12:0] pwm_ch1, [25:13] pwm_ch2, [38:26] pwm_ch3, [51:39] pwm_ch4
   output logic [55:0] rsp_tdata
);

   cfg_type    cfg_ff;
   item_type   item_ff, item_in;
   result_type res_ff, res_in;
   logic       in_vld_ff, out_vld_ff;
   logic       out_ready, in_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.throttle_min   <= 11'd1000;
         cfg_ff.throttle_max   <= 11'd2000;
         cfg_ff.hover_throttle <= 11'd1500;
         cfg_ff.tilt_center    <= 11'd1500;
         cfg_ff.tilt_span      <= 10'd150;
         cfg_ff.yaw_center     <= 11'd1500;
         cfg_ff.yaw_span       <= 10'd50;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_THROTTLE_MIN: cfg_ff.throttle_min   <= csr_wdata;
            REG_THROTTLE_MAX: cfg_ff.throttle_max   <= csr_wdata;
            REG_HOVER:        cfg_ff.hover_throttle <= csr_wdata;
            REG_TILT_CENTER:  cfg_ff.tilt_center    <= csr_wdata;
            REG_TILT_SPAN:    cfg_ff.tilt_span      <= csr_wdata[SPAN_W-1:0];
            REG_YAW_CENTER:   cfg_ff.yaw_center     <= csr_wdata;
            REG_YAW_SPAN:     cfg_ff.yaw_span       <= csr_wdata[SPAN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      item_in.cmd            = req_tuser;
      item_in.stick_throttle = req_tdata[10:0];
      item_in.alt_drive      = req_tdata[23:11];
      item_in.roll_drive     = req_tdata[36:24];
      item_in.pitch_drive    = req_tdata[49:37];
      item_in.yaw_drive      = req_tdata[62:50];
      item_in.armed          = req_tdata[63];
      item_in.wide_yaw       = req_tdata[64];
   end

   // result stage can load when empty or being drained
   assign out_ready  = !out_vld_ff || rsp_tready;
   assign in_ready   = !in_vld_ff || out_ready;
   assign req_tready = in_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         if (in_ready)  in_vld_ff  <= req_tvalid;
         if (out_ready) out_vld_ff <= in_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && req_tvalid) item_ff <= item_in;
      if (out_ready && in_vld_ff) res_ff  <= res_in;
   end

   qxmm_mix_core u_mix (
      .cfg  (cfg_ff),
      .item (item_ff),
      .res  (res_in)
   );

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {4'b0000, res_ff.pwm_ch4, res_ff.pwm_ch3,
                        res_ff.pwm_ch2, res_ff.pwm_ch1};

endmodule

/* hw/rtl/qxmm_mix_core.sv */
// Combinational mixing, clamping and scaling for one registered transaction.
// Depends on qxmm_pkg.
module qxmm_mix_core
   import qxmm_pkg::*;
(
   input  cfg_type    cfg,
   input  item_type   item,
   output result_type res
);

   function automatic logic signed [SUM_W-1:0] clamp_hi_lo(
      input logic signed [SUM_W-1:0] v,
      input logic signed [SUM_W-1:0] lo,
      input logic signed [SUM_W-1:0] hi);
      logic signed [SUM_W-1:0] t;
      begin
         t = (v > hi) ? hi : v;
         clamp_hi_lo = (t < lo) ? lo : t;
      end
   endfunction

   logic signed [SUM_W-1:0] tmin, tmax, stick, base;
   logic signed [SUM_W-1:0] rol, pit, yaw, alt;
   logic signed [SUM_W-1:0] m [4];
   logic signed [SUM_W-1:0] d [4];
   logic signed [SUM_W-1:0] tilt_lo, tilt_hi, yaw_lo, yaw_hi;
   logic signed [SUM_W-1:0] alt_direct;

   always_comb begin
      tmin  = $signed({5'b0, cfg.throttle_min});
      tmax  = $signed({5'b0, cfg.throttle_max});
      stick = $signed({5'b0, item.stick_throttle});
      alt   = SUM_W'(item.alt_drive);
      rol   = SUM_W'(item.roll_drive);
      pit   = SUM_W'(item.pitch_drive);
      yaw   = SUM_W'(item.yaw_drive);
      base  = (item.cmd == CMD_STICK_MIX) ? stick : alt;

      m[0] = base - rol + pit - yaw;
      m[1] = base + rol + pit + yaw;
      m[2] = base + rol - pit - yaw;
      m[3] = base - rol - pit + yaw;

      tilt_lo = $signed({5'b0, cfg.tilt_center}) - $signed({6'b0, cfg.tilt_span});
      tilt_hi = $signed({5'b0, cfg.tilt_center}) + $signed({6'b0, cfg.tilt_span});
      yaw_lo  = $signed({5'b0, cfg.yaw_center}) - $signed({6'b0, cfg.yaw_span});
      yaw_hi  = $signed({5'b0, cfg.yaw_center}) + $signed({6'b0, cfg.yaw_span});
      alt_direct = alt + $signed({5'b0, cfg.hover_throttle});

      // bit 1 of cmd selects direct mode, so the unused code behaves as direct
      if (item.cmd[1]) begin
         d[0] = clamp_hi_lo(rol, tilt_lo, tilt_hi);
         d[1] = clamp_hi_lo(pit, tilt_lo, tilt_hi);
         d[2] = clamp_hi_lo(alt_direct, DIRECT_ALT_LO, DIRECT_ALT_HI);
         d[3] = item.wide_yaw ? clamp_hi_lo(yaw, WIDE_YAW_LO, WIDE_YAW_HI)
                              : clamp_hi_lo(yaw, yaw_lo, yaw_hi);
      end else if (!item.armed) begin
         for (int i = 0; i < 4; i++) d[i] = tmin;
      end else if (stick > tmin + STICK_MARGIN) begin
         // inverted limits: below the lower limit gives the lower, all else the upper
         for (int i = 0; i < 4; i++) begin
            if (m[i] < tmin) begin
               d[i] = tmin;
            end else if (m[i] > tmax) begin
               d[i] = tmax;
            end else begin
               d[i] = m[i];
            end
         end
      end else begin
         for (int i = 0; i < 4; i++) d[i] = stick + STICK_MARGIN;
      end

      res.pwm_ch1 = scale_drive(d[0]);
      res.pwm_ch2 = scale_drive(d[1]);
      res.pwm_ch3 = scale_drive(d[2]);
      res.pwm_ch4 = scale_drive(d[3]);
   end

endmodule
